// ===== hdl/bpr_pkg.sv =====
// package for the buffer pool replacement unit: sizes, codes and shared types
package bpr_pkg;

  localparam int NumFrames = 16;
  localparam int MaxPins   = 15;
  localparam int FrameW    = $clog2(NumFrames);
  localparam int CountW    = $clog2(NumFrames + 1);
  localparam int PinW      = 4;
  localparam int PageW     = 16;
  localparam int StampW    = 32;
  localparam int SweepW    = $clog2(2 * NumFrames + 1);

  // configuration register indexes
  localparam logic CfgPolicy = 1'b0;
  localparam logic CfgFrames = 1'b1;

  // request codes
  localparam logic ReqAccess  = 1'b0;
  localparam logic ReqRelease = 1'b1;

  // policy codes
  localparam logic PolLru   = 1'b0;
  localparam logic PolClock = 1'b1;

  // one result word
  typedef struct packed {
    logic              ok;
    logic              hit;
    logic [FrameW-1:0] frame_index;
    logic              evicted;
    logic [PageW-1:0]  evicted_page;
    logic              write_back;
    logic [PinW-1:0]   pins_now;
  } result_t;

endpackage

// ===== hdl/bpr_ram.sv =====
// generic single-port ram with registered read
module bpr_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== hdl/buffer_pool_replacement_unit.sv =====
// top level of the buffer pool replacement unit
//
//  channel  | signals                               | direction
//  req      | req_valid/req_ready + payload         | in
//  res      | res_valid/res_ready + payload         | out
//  cfg      | cfg_valid/cfg_ready, cfg_index/data   | in
//
// one word: accept, then the lookup reads and compares one frame at a time and
// finishes; a miss then scans for a free frame and, if none is found, runs a
// least-recently-used search or the clock sweep, then, if a victim is found,
// reads, evicts and loads.
// reset empties every frame and clears the counters at once.
// the result sits in an output register; the request side stays not ready
// until that register is free again.
module buffer_pool_replacement_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  logic        req_type_i,
  input  logic [15:0] page_id_i,
  input  logic        is_write_i,
  input  logic        page_valid_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic        ok_o,
  output logic        hit_o,
  output logic [3:0]  frame_index_o,
  output logic        evicted_o,
  output logic [15:0] evicted_page_o,
  output logic        write_back_o,
  output logic [3:0]  pins_now_o,
  output logic [31:0] hit_total_o,
  output logic [31:0] miss_total_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [4:0]  cfg_data_i
);

  localparam int FW = bpr_pkg::FrameW;
  localparam int NF = bpr_pkg::NumFrames;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StRead  = 4'd1;
  localparam logic [3:0] StLook  = 4'd2;
  localparam logic [3:0] StFree  = 4'd3;
  localparam logic [3:0] StLru   = 4'd4;
  localparam logic [3:0] StClock = 4'd5;
  localparam logic [3:0] StEvRd  = 4'd6;
  localparam logic [3:0] StEvict = 4'd7;
  localparam logic [3:0] StLoad  = 4'd8;
  localparam logic [3:0] StDone  = 4'd9;

  logic [3:0] state_q;
  logic       policy_q;
  logic [4:0] frames_q;
  logic [NF-1:0] valid_q, dirty_q, ref_q;
  logic [bpr_pkg::PinW-1:0]   pins_q  [NF];
  logic [bpr_pkg::StampW-1:0] stamp_q [NF];
  logic [31:0] clock_q, hits_q, misses_q;
  logic [FW-1:0] hand_q, idx_q, best_q;
  logic          best_ok_q, found_q;
  logic [bpr_pkg::SweepW-1:0] steps_q;
  logic          req_q, wr_q, pv_q;
  logic [15:0]   page_q;
  logic [FW:0]   n_act;
  bpr_pkg::result_t res_q;
  logic          res_valid_q;

  // page ram port
  logic          ram_we;
  logic [FW-1:0] ram_addr;
  logic [15:0]   ram_rdata;

  bpr_ram #(.Width(bpr_pkg::PageW), .Depth(NF)) u_page_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(page_q),
    .rdata_o(ram_rdata)
  );

  // active frame count, clamped
  always_comb begin
    if (frames_q == 5'd0) n_act = (FW+1)'(1);
    else if (frames_q > 5'(NF)) n_act = (FW+1)'(NF);
    else n_act = (FW+1)'(frames_q);
  end

  logic          last_idx;
  logic [FW-1:0] idx_inc;
  logic [FW-1:0] hand_nx;
  assign last_idx = ((FW+1)'(idx_q) + 1'b1) >= n_act;
  assign idx_inc  = idx_q + 1'b1;
  assign hand_nx  = (((FW+1)'(hand_q) + 1'b1) >= n_act) ? '0 : hand_q + 1'b1;

  assign ram_we   = (state_q == StLoad) && pv_q;
  assign ram_addr = (state_q == StLook || state_q == StRead) ? idx_q :
                    (state_q == StEvRd || state_q == StLoad) ? best_q : idx_q;

  assign req_ready_o = (state_q == StIdle) && !res_valid_q;
  assign cfg_ready_o = 1'b1;
  assign res_valid_o = res_valid_q;
  assign ok_o = res_q.ok;
  assign hit_o = res_q.hit;
  assign frame_index_o = res_q.frame_index;
  assign evicted_o = res_q.evicted;
  assign evicted_page_o = res_q.evicted_page;
  assign write_back_o = res_q.write_back;
  assign pins_now_o = res_q.pins_now;
  assign hit_total_o = hits_q;
  assign miss_total_o = misses_q;

  logic [31:0] clock_inc;
  assign clock_inc = (clock_q == '1) ? clock_q : clock_q + 1'b1;

  // sequencer walking the frames one at a time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      policy_q <= 1'b0;
      frames_q <= 5'd16;
      valid_q <= '0;
      dirty_q <= '0;
      ref_q <= '0;
      for (int i = 0; i < NF; i++) begin
        pins_q[i] <= '0;
        stamp_q[i] <= '0;
      end
      clock_q <= '0;
      hits_q <= '0;
      misses_q <= '0;
      hand_q <= '0;
      idx_q <= '0;
      best_q <= '0;
      best_ok_q <= 1'b0;
      found_q <= 1'b0;
      steps_q <= '0;
      res_valid_q <= 1'b0;
      res_q <= '0;
      req_q <= 1'b0;
      wr_q <= 1'b0;
      pv_q <= 1'b0;
      page_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == bpr_pkg::CfgPolicy) policy_q <= cfg_data_i[0];
        else frames_q <= cfg_data_i;
      end
      if (res_valid_q && res_ready_i) res_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (req_valid_i && req_ready_o) begin
            req_q <= req_type_i;
            page_q <= page_id_i;
            wr_q <= is_write_i;
            pv_q <= page_valid_i;
            idx_q <= '0;
            found_q <= 1'b0;
            res_q <= '0;
            state_q <= StRead;
          end
        end
        StRead: state_q <= StLook;
        // compare the frame at idx; ram read of idx was issued last cycle
        StLook: begin
          if (valid_q[idx_q] && ram_rdata == page_q) begin
            best_q <= idx_q;
            found_q <= 1'b1;
            state_q <= StDone;
          end else if (last_idx) begin
            state_q <= StDone;
          end else begin
            idx_q <= idx_inc;
            state_q <= StRead;
          end
        end
        StFree: begin
          if (!valid_q[idx_q]) begin
            best_q <= idx_q;
            state_q <= StLoad;
          end else if (last_idx) begin
            idx_q <= '0;
            best_ok_q <= 1'b0;
            if (policy_q == bpr_pkg::PolLru) begin
              state_q <= StLru;
            end else begin
              if ((FW+1)'(hand_q) >= n_act) hand_q <= '0;
              steps_q <= '0;
              state_q <= StClock;
            end
          end else begin
            idx_q <= idx_inc;
          end
        end
        StLru: begin
          if (valid_q[idx_q] && pins_q[idx_q] == '0 &&
              (!best_ok_q || stamp_q[idx_q] < stamp_q[best_q])) begin
            best_q <= idx_q;
            best_ok_q <= 1'b1;
          end
          if (last_idx) state_q <= StEvRd;
          else idx_q <= idx_inc;
        end
        StClock: begin
          if (steps_q >= bpr_pkg::SweepW'({n_act, 1'b0})) begin
            state_q <= StEvRd;
          end else begin
            steps_q <= steps_q + 1'b1;
            hand_q <= hand_nx;
            if (valid_q[hand_q] && pins_q[hand_q] == '0) begin
              if (!ref_q[hand_q]) begin
                best_q <= hand_q;
                best_ok_q <= 1'b1;
                state_q <= StEvRd;
              end else begin
                ref_q[hand_q] <= 1'b0;
              end
            end
          end
        end
        StEvRd: begin
          if (best_ok_q) state_q <= StEvict;
          else begin
            res_valid_q <= 1'b1;
            state_q <= StIdle;
          end
        end
        StEvict: begin
          res_q.evicted <= 1'b1;
          res_q.evicted_page <= ram_rdata;
          res_q.write_back <= dirty_q[best_q];
          valid_q[best_q] <= 1'b0;
          dirty_q[best_q] <= 1'b0;
          stamp_q[best_q] <= '0;
          ref_q[best_q] <= 1'b0;
          pins_q[best_q] <= '0;
          state_q <= StLoad;
        end
        StLoad: begin
          if (pv_q) begin
            valid_q[best_q] <= 1'b1;
            dirty_q[best_q] <= wr_q;
            ref_q[best_q] <= 1'b1;
            pins_q[best_q] <= bpr_pkg::PinW'(1);
            stamp_q[best_q] <= clock_inc;
            clock_q <= clock_inc;
            res_q.ok <= 1'b1;
            res_q.frame_index <= best_q;
            res_q.pins_now <= bpr_pkg::PinW'(1);
          end
          res_valid_q <= 1'b1;
          state_q <= StIdle;
        end
        StDone: begin
          if (found_q) begin
            state_q <= StIdle;
            res_valid_q <= 1'b1;
            res_q.ok <= 1'b1;
            res_q.hit <= 1'b1;
            res_q.frame_index <= best_q;
            if (req_q == bpr_pkg::ReqRelease) begin
              if (pins_q[best_q] != '0) begin
                pins_q[best_q] <= pins_q[best_q] - 1'b1;
                res_q.pins_now <= pins_q[best_q] - 1'b1;
              end else begin
                res_q.pins_now <= '0;
              end
            end else begin
              if (hits_q != '1) hits_q <= hits_q + 1'b1;
              if (wr_q) dirty_q[best_q] <= 1'b1;
              clock_q <= clock_inc;
              stamp_q[best_q] <= clock_inc;
              ref_q[best_q] <= 1'b1;
              if (pins_q[best_q] < bpr_pkg::PinW'(bpr_pkg::MaxPins)) begin
                pins_q[best_q] <= pins_q[best_q] + 1'b1;
                res_q.pins_now <= pins_q[best_q] + 1'b1;
              end else begin
                res_q.pins_now <= pins_q[best_q];
              end
            end
          end else if (req_q == bpr_pkg::ReqAccess) begin
            if (misses_q != '1) misses_q <= misses_q + 1'b1;
            idx_q <= '0;
            state_q <= StFree;
          end else begin
            // release of a page that is not resident
            state_q <= StIdle;
            res_valid_q <= 1'b1;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

`ifndef SYNTHESIS
  // result register is only written while no word is waiting
  a_busy_no_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !res_valid_q) else $error("result valid while busy");
  // a hit always reports ok and never an eviction
  a_hit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.hit) |-> (res_q.ok && !res_q.evicted))
    else $error("hit with bad flags");
  // hit counter never goes down
  a_hits_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (hits_q >= $past(hits_q))) else $error("hit count fell");
  // a failed result carries no frame
  a_fail_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_q.ok) |-> (res_q.frame_index == '0 && res_q.pins_now == '0))
    else $error("failed result with frame");
`endif

endmodule
